### hw/rtl/mwk_pkg.sv
`default_nettype none
package mwk_pkg;

  // Register map, word addresses (byte address / 4).
  localparam logic [1:0] REG_LEVER_SUM      = 2'd0;
  localparam logic [1:0] REG_INVERSE_RADIUS = 2'd1;
  localparam logic [1:0] REG_SPEED_LIMIT    = 2'd2;

  localparam logic [15:0] LEVER_SUM_RESET      = 16'd5325;
  localparam logic [15:0] INVERSE_RADIUS_RESET = 16'd2048;
  localparam logic [18:0] SPEED_LIMIT_RESET    = 19'd81920;

  // Wheel magnitude after the radius product, and the quotient width of the divider.
  localparam int unsigned MagW    = 28;
  localparam int unsigned DivBits = 19;

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] yaw_rate;
  } cmd_t;

  typedef struct packed {
    logic signed [19:0] front_left;
    logic signed [19:0] front_right;
    logic signed [19:0] rear_left;
    logic signed [19:0] rear_right;
    logic               was_scaled;
  } wheel_t;

  // One slot of the divider pipeline, four wheels wide.
  typedef struct packed {
    logic [3:0][MagW-1:0]    rem;
    logic [3:0][DivBits-1:0] nq;
    logic [MagW-1:0]         den;
    logic [3:0][DivBits-1:0] raw;
    logic [3:0]              neg;
    logic                    scaled;
  } div_t;

endpackage
`default_nettype wire

### hw/rtl/mecanum_wheel_kinematics.sv
`default_nettype none
// Channel   Ports                                   Carries
// input     in_valid, in_ready, in_data             vel_x, vel_y, yaw_rate
// result    out_valid, out_ready, out_data          four wheel speeds, was_scaled
// config    psel, penable, pwrite, paddr, pwdata,   lever_sum, inverse_radius,
//           prdata, pready                          speed_limit
//
// One transaction enters per cycle while the pipeline is not held by a waiting result;
// most of the pipeline is the 19-stage restoring divider that applies the speed limit.
// Reset is synchronous and active low; it clears the valid bits and loads the
// register defaults. The whole pipeline holds when a result waits and out_ready is
// low, so nothing is lost or repeated.
module mecanum_wheel_kinematics (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire mwk_pkg::cmd_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output mwk_pkg::wheel_t    out_data,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned MagW    = mwk_pkg::MagW;
  localparam int unsigned DivBits = mwk_pkg::DivBits;

  logic [15:0] lever_sum_r;
  logic [15:0] inverse_radius_r;
  logic [18:0] speed_limit_r;
  logic        cfg_wr;
  logic        en;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lever_sum_r      <= mwk_pkg::LEVER_SUM_RESET;
      inverse_radius_r <= mwk_pkg::INVERSE_RADIUS_RESET;
      speed_limit_r    <= mwk_pkg::SPEED_LIMIT_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        mwk_pkg::REG_LEVER_SUM:      lever_sum_r      <= pwdata[15:0];
        mwk_pkg::REG_INVERSE_RADIUS: inverse_radius_r <= pwdata[15:0];
        mwk_pkg::REG_SPEED_LIMIT:    speed_limit_r    <= pwdata[18:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      mwk_pkg::REG_LEVER_SUM:      prdata = {16'd0, lever_sum_r};
      mwk_pkg::REG_INVERSE_RADIUS: prdata = {16'd0, inverse_radius_r};
      mwk_pkg::REG_SPEED_LIMIT:    prdata = {13'd0, speed_limit_r};
      default:                     prdata = 32'd0;
    endcase
  end

  // The pipeline moves as one whenever the output register is free or being taken.
  assign en       = out_ready | ~out_valid;
  assign in_ready = en;

  // Stage 1: yaw term.
  logic               s1_v_r;
  logic signed [32:0] s1_rot_r;
  logic signed [15:0] s1_vx_r;
  logic signed [15:0] s1_vy_r;
  logic signed [32:0] s1_rot_nxt;

  assign s1_rot_nxt = 33'(in_data.yaw_rate * $signed({1'b0, lever_sum_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_rot_r <= s1_rot_nxt;
      s1_vx_r  <= in_data.vel_x;
      s1_vy_r  <= in_data.vel_y;
    end
  end

  // Stage 2: the four wheel sums in Q.24, kept as sign and magnitude.
  logic                   s2_v_r;
  logic [3:0][31:0]       s2_mag_r;
  logic [3:0]             s2_neg_r;
  logic signed [3:0][33:0] s2_sum;
  logic signed [33:0]     vx_w;
  logic signed [33:0]     vy_w;
  logic signed [33:0]     rot_w;
  logic [3:0][31:0]       s2_mag_nxt;
  logic [3:0]             s2_neg_nxt;

  always_comb begin
    vx_w  = 34'($signed({s1_vx_r, 12'd0}));
    vy_w  = 34'($signed({s1_vy_r, 12'd0}));
    rot_w = 34'(s1_rot_r);
    s2_sum[0] = vx_w - vy_w - rot_w;
    s2_sum[1] = vx_w + vy_w + rot_w;
    s2_sum[2] = vx_w + vy_w - rot_w;
    s2_sum[3] = vx_w - vy_w + rot_w;
    for (int w = 0; w < 4; w++) begin
      s2_neg_nxt[w] = s2_sum[w][33];
      s2_mag_nxt[w] = s2_sum[w][33] ? 32'(-s2_sum[w]) : s2_sum[w][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_mag_r <= s2_mag_nxt;
      s2_neg_r <= s2_neg_nxt;
    end
  end

  // Stage 3: multiply by the inverse radius and truncate to Q.12.
  logic                  s3_v_r;
  logic [3:0][MagW-1:0]  s3_mag_r;
  logic [3:0]            s3_neg_r;
  logic [3:0][47:0]      s3_prod;
  logic [3:0][MagW-1:0]  s3_mag_nxt;

  always_comb begin
    for (int w = 0; w < 4; w++) begin
      s3_prod[w]    = 48'(s2_mag_r[w]) * 48'(inverse_radius_r);
      s3_mag_nxt[w] = s3_prod[w][20 +: MagW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_mag_r <= s3_mag_nxt;
      s3_neg_r <= s2_neg_r;
    end
  end

  // Stage 4: largest magnitude and the limit test.
  logic                 s4_v_r;
  logic [3:0][MagW-1:0] s4_mag_r;
  logic [3:0]           s4_neg_r;
  logic [MagW-1:0]      s4_big_r;
  logic                 s4_scaled_r;
  logic [MagW-1:0]      big_a;
  logic [MagW-1:0]      big_b;
  logic [MagW-1:0]      s4_big_nxt;

  always_comb begin
    big_a      = (s3_mag_r[0] > s3_mag_r[1]) ? s3_mag_r[0] : s3_mag_r[1];
    big_b      = (s3_mag_r[2] > s3_mag_r[3]) ? s3_mag_r[2] : s3_mag_r[3];
    s4_big_nxt = (big_a > big_b) ? big_a : big_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_mag_r    <= s3_mag_r;
      s4_neg_r    <= s3_neg_r;
      s4_big_r    <= s4_big_nxt;
      s4_scaled_r <= s4_big_nxt > MagW'(speed_limit_r);
    end
  end

  // Stage 5: numerators for the scaling divide, loaded into the divider's first slot.
  // The quotient never exceeds the limit, so the top bits of the numerator start
  // out below the divisor and only the quotient-width low bits remain to shift in.
  mwk_pkg::div_t        div_r [0:DivBits];
  logic [DivBits:0]     div_v_r;
  mwk_pkg::div_t        div0_nxt;
  logic [3:0][MagW+DivBits-1:0] num;

  always_comb begin
    div0_nxt.den    = s4_big_r;
    div0_nxt.neg    = s4_neg_r;
    div0_nxt.scaled = s4_scaled_r;
    for (int w = 0; w < 4; w++) begin
      num[w]          = (MagW+DivBits)'(s4_mag_r[w]) * (MagW+DivBits)'(speed_limit_r);
      div0_nxt.rem[w] = num[w][DivBits +: MagW];
      div0_nxt.nq[w]  = num[w][DivBits-1:0];
      div0_nxt.raw[w] = s4_mag_r[w][DivBits-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_v_r[0] <= 1'b0;
    end else if (en) begin
      div_v_r[0] <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r[0] <= div0_nxt;
    end
  end

  // Restoring divider: one quotient bit per stage for all four wheels.
  for (genvar k = 0; k < DivBits; k++) begin : g_div
    mwk_pkg::div_t          step_nxt;
    logic [3:0][MagW:0]     trial;
    logic [3:0][MagW:0]     diff;
    logic [3:0]             qbit;

    always_comb begin
      step_nxt = div_r[k];
      for (int w = 0; w < 4; w++) begin
        trial[w] = {div_r[k].rem[w], div_r[k].nq[w][DivBits-1]};
        diff[w]  = trial[w] - {1'b0, div_r[k].den};
        qbit[w]  = trial[w] >= {1'b0, div_r[k].den};
        step_nxt.rem[w] = qbit[w] ? diff[w][MagW-1:0] : trial[w][MagW-1:0];
        step_nxt.nq[w]  = {div_r[k].nq[w][DivBits-2:0], qbit[w]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_v_r[k+1] <= 1'b0;
      end else if (en) begin
        div_v_r[k+1] <= div_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        div_r[k+1] <= step_nxt;
      end
    end
  end

  // Output register: pick quotient or unscaled speed and restore the sign.
  mwk_pkg::wheel_t       out_r;
  logic                  out_v_r;
  mwk_pkg::wheel_t       out_nxt;
  logic [3:0][DivBits-1:0] pick;
  logic [3:0][19:0]      spd;

  always_comb begin
    for (int w = 0; w < 4; w++) begin
      pick[w] = div_r[DivBits].scaled ? div_r[DivBits].nq[w] : div_r[DivBits].raw[w];
      spd[w]  = div_r[DivBits].neg[w] ? 20'(-{1'b0, pick[w]}) : 20'({1'b0, pick[w]});
    end
    out_nxt.front_left  = spd[0];
    out_nxt.front_right = spd[1];
    out_nxt.rear_left   = spd[2];
    out_nxt.rear_right  = spd[3];
    out_nxt.was_scaled  = div_r[DivBits].scaled;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= div_v_r[DivBits];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

### hw/rtl/mwk_checker.sv
`default_nettype none
module mwk_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_valid,
  input wire logic            in_ready,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire mwk_pkg::wheel_t out_data,
  input wire logic            pready
);

  // A result that is not taken stays, unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or vanished while stalled");

  // The input side only stalls behind a waiting result.
  a_in_stall: assert property (@(posedge clk)
    in_valid && !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back pressure");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  // The configuration port never inserts wait states.
  a_pready: assert property (@(posedge clk) pready)
    else $error("pready dropped");

endmodule

bind mecanum_wheel_kinematics mwk_checker u_mwk_checker (.*);
`default_nettype wire
